// ----- sv/spq_pkg.sv -----
// Shared types and codes for the stable priority ready queue.
// No dependencies; used by spq_cell and stable_priority_ready_queue_top.
`default_nettype none
package spq_pkg;

  typedef enum logic [1:0] {
    OP_ENQUEUE = 2'd0,
    OP_TAKE    = 2'd1,
    OP_REMOVE  = 2'd2,
    OP_FIND    = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_EMPTY     = 2'd1,
    STS_NOT_FOUND = 2'd2,
    STS_FULL      = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    CMD_HOLD,
    CMD_INSERT,
    CMD_POP,
    CMD_START,
    CMD_STEP,
    CMD_REMOVE,
    CMD_CLEAR
  } cmd_t;

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  // Broadcast to every cell.
  typedef struct packed {
    cmd_t       cmd;
    logic [7:0] id;
    logic [7:0] prio;
  } cell_ctl_t;

  // What a cell shows its neighbors.
  typedef struct packed {
    logic       head;   // only the virtual slot ahead of cell 0
    logic       valid;
    logic [7:0] id;
    logic [7:0] prio;
    logic       le;     // valid and prio <= request priority
    logic       tok;    // search token moving on to the next cell
  } cell_link_t;

  // Per-cell status, reduced in the top level.
  typedef struct packed {
    logic       hit;
    logic       miss;
    logic [7:0] id;     // zero unless hit
    logic [7:0] prio;   // zero unless hit
  } cell_stat_t;

  localparam cell_link_t LINK_HEAD = '{head: 1'b1, valid: 1'b0, id: 8'd0, prio: 8'd0,
                                       le: 1'b1, tok: 1'b0};
  localparam cell_link_t LINK_NONE = '0;

endpackage
`default_nettype wire

// ----- sv/spq_cell.sv -----
// One slot of the sorted queue: entry, valid, search token and visited mark.
// Depends on spq_pkg.
`default_nettype none
module spq_cell (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire spq_pkg::cell_ctl_t  ctl,
  input  wire spq_pkg::cell_link_t left_i,
  input  wire spq_pkg::cell_link_t right_i,
  output spq_pkg::cell_link_t      link_o,
  output spq_pkg::cell_stat_t      stat_o
);

  logic [7:0] id_r, id_nxt;
  logic [7:0] prio_r, prio_nxt;
  logic       valid_r, valid_nxt;
  logic       tok_r, tok_nxt;
  logic       visited_r, visited_nxt;
  logic       hit, le;

  assign hit = tok_r & valid_r & (id_r == ctl.id);
  assign le  = valid_r & (prio_r <= ctl.prio);

  always_comb begin
    link_o.head  = 1'b0;
    link_o.valid = valid_r;
    link_o.id    = id_r;
    link_o.prio  = prio_r;
    link_o.le    = le;
    link_o.tok   = tok_r & valid_r & ~hit;
    stat_o.hit   = hit;
    stat_o.miss  = tok_r & ~valid_r;
    stat_o.id    = hit ? id_r : 8'd0;
    stat_o.prio  = hit ? prio_r : 8'd0;
  end

  always_comb begin
    id_nxt      = id_r;
    prio_nxt    = prio_r;
    valid_nxt   = valid_r;
    tok_nxt     = tok_r;
    visited_nxt = visited_r;
    case (ctl.cmd)
      spq_pkg::CMD_INSERT: begin
        if (!le) begin
          if (left_i.head || left_i.le) begin
            id_nxt    = ctl.id;
            prio_nxt  = ctl.prio;
            valid_nxt = 1'b1;
          end else begin
            id_nxt    = left_i.id;
            prio_nxt  = left_i.prio;
            valid_nxt = left_i.valid;
          end
        end
      end
      spq_pkg::CMD_POP: begin
        id_nxt    = right_i.id;
        prio_nxt  = right_i.prio;
        valid_nxt = right_i.valid;
      end
      spq_pkg::CMD_START: begin
        tok_nxt     = left_i.head;
        visited_nxt = 1'b0;
      end
      spq_pkg::CMD_STEP: begin
        tok_nxt     = left_i.tok;
        visited_nxt = visited_r | tok_r;
      end
      spq_pkg::CMD_REMOVE: begin
        // slots ahead of the hit keep their entry, the rest close the gap
        if (!visited_r) begin
          id_nxt    = right_i.id;
          prio_nxt  = right_i.prio;
          valid_nxt = right_i.valid;
        end
        tok_nxt     = 1'b0;
        visited_nxt = 1'b0;
      end
      spq_pkg::CMD_CLEAR: begin
        tok_nxt     = 1'b0;
        visited_nxt = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
    if (!rst_n) begin
      valid_r   <= 1'b0;
      tok_r     <= 1'b0;
      visited_r <= 1'b0;
    end else begin
      valid_r   <= valid_nxt;
      tok_r     <= tok_nxt;
      visited_r <= visited_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- sv/stable_priority_ready_queue_top.sv -----
// Top level of the stable priority ready queue: a row of spq_cell slots,
// the sequencer for remove/find searches, occupancy count and output register.
// Depends on spq_pkg and spq_cell.
//
//  channel  | ports                                          | flow control
//  ---------+------------------------------------------------+---------------------
//  input    | in_operation, in_thread_id, in_priority_req    | in_valid / in_stall
//  result   | out_status, out_result_id, out_result_priority, | out_valid / out_stall
//           | out_occupancy                                   |
//
// Enqueue and take head settle in the cell row at the accepting edge; their result
// beat is registered at that same edge, so these sustain one beat per cycle while
// the output is not stalled. Remove and find pass a search token down the row one
// cell per cycle while the output is not stalled; a match, or a miss where the
// token reaches an empty slot or drops off the last slot of a full queue, is loaded
// into the output register, and the next input beat is accepted at the earliest
// once the sequencer is back in idle.
// Reset (rst_n low, synchronous) clears the valid bits, tokens, count and
// output valid; no sweep follows. out_stall freezes the search token while a
// result waits, and the input is stalled while a search runs or the output is full.

`default_nettype none
module stable_priority_ready_queue_top #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_thread_id,
  input  wire logic [7:0] in_priority_req,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [1:0]      out_status,
  output logic [7:0]      out_result_id,
  output logic [7:0]      out_result_priority,
  output logic [4:0]      out_occupancy
);

  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  spq_pkg::cell_ctl_t  ctl;
  spq_pkg::cell_link_t link  [QUEUE_DEPTH];
  spq_pkg::cell_link_t left  [QUEUE_DEPTH];
  spq_pkg::cell_link_t right [QUEUE_DEPTH];
  spq_pkg::cell_stat_t stat  [QUEUE_DEPTH];

  spq_pkg::state_t state_r, state_nxt;
  spq_pkg::op_t    in_op;
  logic            search_rm_r, search_rm_nxt;
  logic [7:0]      search_id_r, search_id_nxt;
  logic [CW-1:0]   count_r, count_nxt;

  logic            out_valid_r, out_valid_nxt;
  logic [1:0]      out_status_r, out_status_nxt;
  logic [7:0]      out_id_r, out_id_nxt;
  logic [7:0]      out_prio_r, out_prio_nxt;
  logic [4:0]      out_occ_r, out_occ_nxt;

  logic            out_free, accept, full, empty;
  logic            any_hit, any_miss;
  logic [7:0]      hit_id, hit_prio;

  assign in_op    = spq_pkg::op_t'(in_operation);
  assign out_free = !out_valid_r || !out_stall;
  assign accept   = in_valid && !in_stall;
  assign full     = (count_r == CW'(QUEUE_DEPTH));
  assign empty    = (count_r == '0);

  // cell row; slot 0 is the head
  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign left[i] = spq_pkg::LINK_HEAD;
    end else begin : g_mid_l
      assign left[i] = link[i-1];
    end
    if (i == QUEUE_DEPTH - 1) begin : g_last
      assign right[i] = spq_pkg::LINK_NONE;
    end else begin : g_mid_r
      assign right[i] = link[i+1];
    end
    spq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctl     (ctl),
      .left_i  (left[i]),
      .right_i (right[i]),
      .link_o  (link[i]),
      .stat_o  (stat[i])
    );
  end

  // at most one cell hits; a token leaving the last slot is a miss too
  always_comb begin
    any_hit  = 1'b0;
    any_miss = link[QUEUE_DEPTH-1].tok;
    hit_id   = 8'd0;
    hit_prio = 8'd0;
    for (int i = 0; i < QUEUE_DEPTH; i++) begin
      any_hit  = any_hit | stat[i].hit;
      any_miss = any_miss | stat[i].miss;
      hit_id   = hit_id | stat[i].id;
      hit_prio = hit_prio | stat[i].prio;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        if (accept && (in_op inside {spq_pkg::OP_REMOVE, spq_pkg::OP_FIND})) begin
          state_nxt = spq_pkg::ST_SEARCH;
        end
      end
      spq_pkg::ST_SEARCH: begin
        if (out_free && (any_hit || any_miss)) begin
          state_nxt = spq_pkg::ST_IDLE;
        end
      end
      default: state_nxt = spq_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer: cell command, result load, count update
  always_comb begin
    in_stall       = 1'b1;
    ctl.cmd        = spq_pkg::CMD_HOLD;
    ctl.id         = in_thread_id;
    ctl.prio       = in_priority_req;
    search_rm_nxt  = search_rm_r;
    search_id_nxt  = search_id_r;
    count_nxt      = count_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_id_nxt     = out_id_r;
    out_prio_nxt   = out_prio_r;
    out_occ_nxt    = out_occ_r;
    case (state_r)
      spq_pkg::ST_IDLE: begin
        in_stall = !out_free;
        if (accept) begin
          case (in_op)
            spq_pkg::OP_ENQUEUE: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = spq_pkg::STS_FULL;
                out_id_nxt     = 8'd0;
                out_prio_nxt   = 8'd0;
                out_occ_nxt    = 5'(count_r);
              end else begin
                ctl.cmd        = spq_pkg::CMD_INSERT;
                count_nxt      = count_r + CW'(1);
                out_status_nxt = spq_pkg::STS_OK;
                out_id_nxt     = in_thread_id;
                out_prio_nxt   = in_priority_req;
                out_occ_nxt    = 5'(count_r + CW'(1));
              end
            end
            spq_pkg::OP_TAKE: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_status_nxt = spq_pkg::STS_EMPTY;
                out_id_nxt     = 8'd0;
                out_prio_nxt   = 8'd0;
                out_occ_nxt    = 5'(count_r);
              end else begin
                ctl.cmd        = spq_pkg::CMD_POP;
                count_nxt      = count_r - CW'(1);
                out_status_nxt = spq_pkg::STS_OK;
                out_id_nxt     = link[0].id;
                out_prio_nxt   = link[0].prio;
                out_occ_nxt    = 5'(count_r - CW'(1));
              end
            end
            default: begin
              ctl.cmd       = spq_pkg::CMD_START;
              search_rm_nxt = (in_op == spq_pkg::OP_REMOVE);
              search_id_nxt = in_thread_id;
            end
          endcase
        end
      end
      spq_pkg::ST_SEARCH: begin
        ctl.id = search_id_r;
        if (out_free) begin
          if (any_hit) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = spq_pkg::STS_OK;
            out_id_nxt     = hit_id;
            out_prio_nxt   = hit_prio;
            if (search_rm_r) begin
              ctl.cmd     = spq_pkg::CMD_REMOVE;
              count_nxt   = count_r - CW'(1);
              out_occ_nxt = 5'(count_r - CW'(1));
            end else begin
              ctl.cmd     = spq_pkg::CMD_CLEAR;
              out_occ_nxt = 5'(count_r);
            end
          end else if (any_miss) begin
            ctl.cmd        = spq_pkg::CMD_CLEAR;
            out_valid_nxt  = 1'b1;
            out_status_nxt = spq_pkg::STS_NOT_FOUND;
            out_id_nxt     = 8'd0;
            out_prio_nxt   = 8'd0;
            out_occ_nxt    = 5'(count_r);
          end else begin
            ctl.cmd = spq_pkg::CMD_STEP;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    search_rm_r  <= search_rm_nxt;
    search_id_r  <= search_id_nxt;
    out_status_r <= out_status_nxt;
    out_id_r     <= out_id_nxt;
    out_prio_r   <= out_prio_nxt;
    out_occ_r    <= out_occ_nxt;
    if (!rst_n) begin
      state_r     <= spq_pkg::ST_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = out_status_r;
  assign out_result_id       = out_id_r;
  assign out_result_priority = out_prio_r;
  assign out_occupancy       = out_occ_r;

endmodule
`default_nettype wire

// ----- tb/stable_priority_ready_queue_top_tb.sv -----
// Self-checking testbench for stable_priority_ready_queue_top: random and directed beats
// are checked against a scoreboard that keeps its own sorted copy of the ready queue.
// Depends on spq_pkg and the RTL of stable_priority_ready_queue_top.

// One expected result beat.
typedef struct {
  spq_pkg::status_t status;
  bit [7:0]         id;
  bit [7:0]         prio;
  bit [4:0]         occ;
} queue_reply_t;

class ready_queue_scoreboard;
  localparam int DEPTH = 16;

  bit [7:0]     slot_id[$];     // slot 0 is the head
  bit [7:0]     slot_prio[$];
  queue_reply_t replies_due[$];
  int           errors;
  int           beats_checked;
  int           op_count[4];
  int           status_count[4];

  // Apply one accepted request to the shadow queue and queue up its reply.
  function void note_request(spq_pkg::op_t op, bit [7:0] id, bit [7:0] prio);
    queue_reply_t r;
    int pos;
    int n;
    n = slot_id.size();
    r.status = spq_pkg::STS_OK;
    r.id = 8'd0;
    r.prio = 8'd0;
    case (op)
      spq_pkg::OP_ENQUEUE: begin
        if (n >= DEPTH) begin
          r.status = spq_pkg::STS_FULL;
        end else begin
          // stable: goes behind every entry of lower or equal priority
          pos = 0;
          while (pos < n && slot_prio[pos] <= prio) pos++;
          slot_id.insert(pos, id);
          slot_prio.insert(pos, prio);
          r.id = id;
          r.prio = prio;
        end
      end
      spq_pkg::OP_TAKE: begin
        if (n == 0) begin
          r.status = spq_pkg::STS_EMPTY;
        end else begin
          r.id = slot_id.pop_front();
          r.prio = slot_prio.pop_front();
        end
      end
      default: begin
        pos = 0;
        while (pos < n && slot_id[pos] != id) pos++;
        if (pos >= n) begin
          r.status = spq_pkg::STS_NOT_FOUND;
        end else begin
          r.id = slot_id[pos];
          r.prio = slot_prio[pos];
          if (op == spq_pkg::OP_REMOVE) begin
            slot_id.delete(pos);
            slot_prio.delete(pos);
          end
        end
      end
    endcase
    r.occ = 5'(slot_id.size());
    replies_due.push_back(r);
    op_count[op]++;
  endfunction

  function void check_response(bit [1:0] status, bit [7:0] id, bit [7:0] prio,
                               bit [4:0] occ, longint stamp);
    queue_reply_t e;
    if (replies_due.size() == 0) begin
      $display("%0t: result beat with nothing pending: status %0d id %0d prio %0d occ %0d",
               stamp, status, id, prio, occ);
      errors++;
      return;
    end
    e = replies_due.pop_front();
    beats_checked++;
    status_count[e.status]++;
    if (status != e.status) begin
      $display("%0t: status expected %0d actual %0d", stamp, e.status, status);
      errors++;
    end
    if (id != e.id) begin
      $display("%0t: result_id expected %0d actual %0d", stamp, e.id, id);
      errors++;
    end
    if (prio != e.prio) begin
      $display("%0t: result_priority expected %0d actual %0d", stamp, e.prio, prio);
      errors++;
    end
    if (occ != e.occ) begin
      $display("%0t: occupancy expected %0d actual %0d", stamp, e.occ, occ);
      errors++;
    end
  endfunction

  function int pending_count();
    return replies_due.size();
  endfunction
endclass

module stable_priority_ready_queue_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import spq_pkg::*;

  // Watchdog limit; a correct run ends well before it.
  localparam int CYCLE_LIMIT = 200000;
  // Settle window after the last beat.
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD_CYCLES = 80;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation = 2'd0;
  logic [7:0] in_thread_id = 8'd0;
  logic [7:0] in_priority_req = 8'd0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [1:0] out_status;
  logic [7:0] out_result_id;
  logic [7:0] out_result_priority;
  logic [4:0] out_occupancy;

  ready_queue_scoreboard sb;

  // Shared knobs between the stimulus, the receiver and the main sequence.
  bit       quiet_mode = 1'b0;     // no idling on either side
  bit       long_hold_ask = 1'b0;  // receiver holds off for a long stretch
  bit [7:0] id_pool[8];
  int       cycle_count = 0;

  stable_priority_ready_queue_top #(
    .QUEUE_DEPTH(16)
  ) u_dut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_operation       (in_operation),
    .in_thread_id       (in_thread_id),
    .in_priority_req    (in_priority_req),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_status         (out_status),
    .out_result_id      (out_result_id),
    .out_result_priority(out_result_priority),
    .out_occupancy      (out_occupancy)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Watchdog: a hang or a lost beat ends the run here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Result monitor: sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_response(out_status, out_result_id, out_result_priority, out_occupancy,
                        longint'($time));
    end
  end

  // Receiver: random stalls, or one long hold-off counted here when asked.
  // Exactly one assignment to out_stall per falling edge.
  initial begin
    @(negedge clk);
    forever begin
      if (long_hold_ask) begin
        long_hold_ask = 1'b0;
        repeat (LONG_HOLD_CYCLES) begin
          out_stall <= 1'b1;
          @(negedge clk);
        end
      end else begin
        out_stall <= !quiet_mode && ($urandom_range(0, 99) < 19);
        @(negedge clk);
      end
    end
  end

  // Offer one beat; entered at a falling edge, returns at a falling edge after the
  // beat was accepted. Payload holds while stalled.
  task automatic send_request(op_t op, bit [7:0] id, bit [7:0] prio);
    while (!quiet_mode && $urandom_range(0, 99) < 19) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_thread_id <= id;
    in_priority_req <= prio;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, id, prio);
    @(negedge clk);
  endtask

  // Sender goes quiet until every reply has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (sb.pending_count() != 0) @(negedge clk);
  endtask

  // Random phase. enq_pct/take_pct steer occupancy; the rest is remove/find.
  // Ids mostly come from a small pool so remove/find hit and duplicates occur.
  task automatic run_phase(int count, int enq_pct, int take_pct);
    int r;
    op_t op;
    bit [7:0] id;
    bit [7:0] prio;
    foreach (id_pool[k]) id_pool[k] = 8'($urandom_range(0, 255));
    repeat (count) begin
      r = $urandom_range(0, 99);
      if (r < enq_pct) op = OP_ENQUEUE;
      else if (r < enq_pct + take_pct) op = OP_TAKE;
      else if ($urandom_range(0, 1) == 0) op = OP_REMOVE;
      else op = OP_FIND;
      if ($urandom_range(0, 99) < 65) id = id_pool[$urandom_range(0, 7)];
      else id = 8'($urandom_range(0, 255));
      // coarse priorities give lots of ties
      if ($urandom_range(0, 1) == 0) prio = 8'($urandom_range(0, 3) * 85);
      else prio = 8'($urandom_range(0, 255));
      send_request(op, id, prio);
    end
  endtask

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed: empty-queue failures first.
    send_request(OP_TAKE, 8'd0, 8'd0);
    send_request(OP_REMOVE, 8'd0, 8'hFF);
    send_request(OP_FIND, 8'hFF, 8'd0);
    // Fill to depth: ids 0..255 in steps of 17, extreme and tied priorities.
    for (int i = 0; i < 16; i++) begin
      send_request(OP_ENQUEUE, 8'(i * 17),
                   (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'(8'h40 * (i % 3)));
    end
    send_request(OP_ENQUEUE, 8'h5A, 8'hA5);   // refused, queue full
    send_request(OP_FIND, 8'd34, 8'd0);       // hit mid queue
    send_request(OP_FIND, 8'h5A, 8'd0);       // refused id never got in
    send_request(OP_REMOVE, 8'hFF, 8'd0);     // hit
    send_request(OP_REMOVE, 8'h5A, 8'd0);     // miss on a full-ish queue
    send_request(OP_TAKE, 8'd0, 8'd0);

    // Long stretch with no idling anywhere.
    quiet_mode = 1'b1;
    run_phase(150, 50, 25);
    quiet_mode = 1'b0;
    run_phase(120, 75, 10);
    // Receiver holds off while the sender keeps offering: block backs up.
    long_hold_ask = 1'b1;
    run_phase(120, 40, 30);
    run_phase(120, 10, 70);
    // Sender pause until everything outstanding has come back.
    wait_drained();
    run_phase(150, 45, 25);
    run_phase(120, 70, 10);
    run_phase(150, 30, 10);
    run_phase(120, 15, 60);
    long_hold_ask = 1'b1;
    run_phase(150, 50, 30);
    run_phase(100, 80, 5);
    run_phase(100, 5, 80);

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Covered %0d beats: %0d enqueue, %0d take, %0d remove, %0d find",
             sb.beats_checked, sb.op_count[OP_ENQUEUE], sb.op_count[OP_TAKE],
             sb.op_count[OP_REMOVE], sb.op_count[OP_FIND]);
    $display("Replies by status: %0d ok, %0d empty, %0d not found, %0d full",
             sb.status_count[STS_OK], sb.status_count[STS_EMPTY],
             sb.status_count[STS_NOT_FOUND], sb.status_count[STS_FULL]);
    if (sb.errors == 0 && sb.pending_count() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ----- stable_priority_ready_queue_top.f -----
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_ready_queue_top.sv
tb/stable_priority_ready_queue_top_tb.sv
